[hdl/minv_pkg.sv]
// Shared types, constants and index helpers for the 4x4 matrix inverse.
package minv_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Datapath operations issued by the sequencer.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_LOADA_E,
    OP_LOADA_M,
    OP_MUL,
    OP_COMMIT,
    OP_MINOR_CLR,
    OP_MINOR_ACC,
    OP_DET_CLR,
    OP_DET_ACC,
    OP_DET_FMT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] addr;   // element address, column * 4 + row
    logic [1:0] limb;   // multiplicand limb
    logic       neg;    // subtract / negate
    logic       last;   // final result of the matrix
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
  } dp_stat_t;

  // n-th index of 0..3 that skips the excluded one.
  function automatic logic [1:0] skip_idx(input logic [1:0] ex, input logic [1:0] n);
    return (n < ex) ? n : n + 2'd1;
  endfunction

  // Permutation of the 3x3 Leibniz expansion: row picked for column n of term.
  function automatic logic [1:0] perm_sel(input logic [2:0] term, input logic [1:0] n);
    logic [5:0] p;
    case (term)
      3'd0:    p = {2'd0, 2'd1, 2'd2};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd2, 2'd0, 2'd1};
      3'd5:    p = {2'd2, 2'd1, 2'd0};
      default: p = 6'd0;
    endcase
    if (n == 2'd0) return p[5:4];
    if (n == 2'd1) return p[3:2];
    return p[1:0];
  endfunction

  // Odd permutations carry a minus sign.
  function automatic logic term_neg(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

endpackage

[hdl/minv_ctrl.sv]
// Sequencer: load counter, minor / determinant / divide schedule.
module minv_ctrl #(
  parameter int WORD_BITS = minv_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output minv_pkg::dp_cmd_t  cmd,
  input  minv_pkg::dp_stat_t stat
);
  import minv_pkg::*;

  localparam int SW = $clog2(WORD_BITS);

  typedef enum logic [17:0] {
    S_LOAD   = 18'h00001,
    S_DCLR   = 18'h00002,
    S_MCLR   = 18'h00004,
    S_TLOAD  = 18'h00008,
    S_TMUL1  = 18'h00010,
    S_TCOM1  = 18'h00020,
    S_TMUL2  = 18'h00040,
    S_TCOM2  = 18'h00080,
    S_TACC   = 18'h00100,
    S_DLOAD  = 18'h00200,
    S_DMUL   = 18'h00400,
    S_DCOM   = 18'h00800,
    S_DACC   = 18'h01000,
    S_DFMT   = 18'h02000,
    S_ONEXT  = 18'h04000,
    S_VSTART = 18'h08000,
    S_VSTEP  = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [2:0]    term_r, term_nxt;
  logic [1:0]    limb_r, limb_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          phase_r, phase_nxt;   // 0: determinant, 1: inverse

  logic [1:0] sc, sr;
  logic [3:0] t_addr0, t_addr1, t_addr2;

  // Deleted column / row of the current minor.
  assign sc = phase_r ? idx_r[1:0] : 2'd0;
  assign sr = phase_r ? idx_r[3:2] : idx_r[1:0];

  assign t_addr0 = {skip_idx(sc, 2'd0), skip_idx(sr, perm_sel(term_r, 2'd0))};
  assign t_addr1 = {skip_idx(sc, 2'd1), skip_idx(sr, perm_sel(term_r, 2'd1))};
  assign t_addr2 = {skip_idx(sc, 2'd2), skip_idx(sr, perm_sel(term_r, 2'd2))};

  assign busy = (state_r != S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    term_nxt  = term_r;
    limb_nxt  = limb_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          cmd.op   = OP_WRITE;
          cmd.addr = cnt_r;
          cnt_nxt  = cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_nxt = S_DCLR;
        end
      end
      S_DCLR: begin
        cmd.op    = OP_DET_CLR;
        phase_nxt = 1'b0;
        idx_nxt   = 4'd0;
        state_nxt = S_MCLR;
      end
      S_MCLR: begin
        cmd.op    = OP_MINOR_CLR;
        term_nxt  = 3'd0;
        limb_nxt  = 2'd0;
        state_nxt = S_TLOAD;
      end
      S_TLOAD: begin
        cmd.op    = OP_LOADA_E;
        cmd.addr  = t_addr0;
        state_nxt = S_TMUL1;
      end
      S_TMUL1: begin
        cmd.op    = OP_MUL;
        cmd.addr  = t_addr1;
        state_nxt = S_TCOM1;
      end
      S_TCOM1: begin
        cmd.op    = OP_COMMIT;
        cmd.addr  = t_addr1;
        state_nxt = S_TMUL2;
      end
      S_TMUL2: begin
        cmd.op   = OP_MUL;
        cmd.addr = t_addr2;
        cmd.limb = limb_r;
        if (limb_r == 2'd1) begin
          limb_nxt  = 2'd0;
          state_nxt = S_TCOM2;
        end else begin
          limb_nxt = limb_r + 2'd1;
        end
      end
      S_TCOM2: begin
        cmd.op    = OP_COMMIT;
        cmd.addr  = t_addr2;
        state_nxt = S_TACC;
      end
      S_TACC: begin
        cmd.op  = OP_MINOR_ACC;
        cmd.neg = term_neg(term_r);
        if (term_r == 3'd5) begin
          state_nxt = phase_r ? S_VSTART : S_DLOAD;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = S_TLOAD;
        end
      end
      S_DLOAD: begin
        cmd.op    = OP_LOADA_M;
        limb_nxt  = 2'd0;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.op   = OP_MUL;
        cmd.addr = {2'd0, idx_r[1:0]};
        cmd.limb = limb_r;
        limb_nxt = limb_r + 2'd1;
        if (limb_r == 2'd3) state_nxt = S_DCOM;
      end
      S_DCOM: begin
        cmd.op    = OP_COMMIT;
        cmd.addr  = {2'd0, idx_r[1:0]};
        state_nxt = S_DACC;
      end
      S_DACC: begin
        cmd.op  = OP_DET_ACC;
        cmd.neg = idx_r[0];
        if (idx_r == 4'd3) begin
          idx_nxt   = 4'd0;
          state_nxt = S_DFMT;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_MCLR;
        end
      end
      S_DFMT: begin
        cmd.op    = OP_DET_FMT;
        phase_nxt = 1'b1;
        state_nxt = S_ONEXT;
      end
      S_ONEXT: begin
        state_nxt = stat.singular ? S_EMIT : S_MCLR;
      end
      S_VSTART: begin
        cmd.op    = OP_DIV_START;
        cmd.neg   = idx_r[0] ^ idx_r[2];
        step_nxt  = '0;
        state_nxt = S_VSTEP;
      end
      S_VSTEP: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(WORD_BITS - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op   = OP_EMIT;
        cmd.last = (idx_r == 4'd15);
        if (idx_r == 4'd15) begin
          idx_nxt   = 4'd0;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_ONEXT;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      term_r  <= '0;
      limb_r  <= '0;
      step_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      term_r  <= term_nxt;
      limb_r  <= limb_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

[hdl/minv_dp.sv]
// Datapath: element store, limb multiplier, minor / determinant accumulators, divider.
module minv_dp #(
  parameter int WORD_BITS = minv_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = minv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  minv_pkg::dp_cmd_t           cmd,
  output minv_pkg::dp_stat_t          stat,
  input  logic signed [WORD_BITS-1:0] in_element,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_inverse_element,
  output logic signed [WORD_BITS-1:0] out_determinant,
  output logic                        out_singular,
  output logic                        out_last
);
  import minv_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int AW   = 4 * W;       // multiplicand magnitude
  localparam int PW   = 5 * W;       // product accumulator
  localparam int MINW = 3 * W + 2;   // signed 3x3 minor
  localparam int DW   = 4 * W + 3;   // signed determinant
  localparam int NW   = 5 * W + 4;   // divider numerator / remainder

  localparam logic [W-1:0] POS_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W - 1){1'b0}}};

  logic signed [W-1:0] mem_r [16];

  logic [AW-1:0]         a_mag_r;
  logic                  a_neg_r;
  logic [PW-1:0]         prod_r;
  logic signed [MINW-1:0] minor_r;
  logic signed [DW-1:0]  det_r;
  logic [NW-1:0]         rem_r, dsh_r;
  logic [W-1:0]          quo_r;
  logic                  qneg_r, ovf_r;
  logic [W-1:0]          detq_r;
  logic                  sing_r;
  logic                  valid_r, last_r;
  logic [W-1:0]          inv_r;

  logic signed [W-1:0]    e;
  logic [W-1:0]           e_abs, limb_w;
  logic [2*W-1:0]         mult_w;
  logic signed [AW:0]     a_sv;
  logic signed [MINW:0]   m_ext, mv;
  logic [MINW:0]          mabs;
  logic [DW-1:0]          dabs, dr;
  logic [NW-1:0]          num, den2;
  logic                   ovf_w;
  logic [W-1:0]           detq_w, inv_w;

  assign e      = mem_r[cmd.addr];
  assign e_abs  = e[W-1] ? W'(-e) : W'(e);
  assign limb_w = a_mag_r[cmd.limb * W +: W];
  assign mult_w = limb_w * e_abs;
  assign a_sv   = a_neg_r ? -$signed({1'b0, a_mag_r}) : $signed({1'b0, a_mag_r});

  // Divider setup: |m| * 2^(2F+1) + |d| over 2|d| rounds half away from zero.
  assign m_ext = (MINW + 1)'(minor_r);
  assign mv    = cmd.neg ? -m_ext : m_ext;
  assign mabs  = mv[MINW] ? $unsigned(-mv) : $unsigned(mv);
  assign dabs  = det_r[DW-1] ? $unsigned(-det_r) : $unsigned(det_r);
  assign num   = (NW'(mabs) << (2 * F + 1)) + NW'(dabs);
  assign den2  = NW'(dabs) << 1;
  assign ovf_w = num >= (den2 << W);

  // Determinant in output units, rounded then clamped.
  assign dr = (dabs + (DW'(1) << (3 * F - 1))) >> (3 * F);
  always_comb begin
    if (det_r[DW-1]) begin
      detq_w = (dr > (DW'(1) << (W - 1))) ? NEG_MIN : W'(-dr);
    end else begin
      detq_w = (dr > DW'(POS_MAX)) ? POS_MAX : W'(dr);
    end
  end

  always_comb begin
    if (qneg_r) begin
      inv_w = (ovf_r || (quo_r > NEG_MIN)) ? NEG_MIN : W'(-quo_r);
    end else begin
      inv_w = (ovf_r || (quo_r > POS_MAX)) ? POS_MAX : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) mem_r[cmd.addr] <= in_element;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOADA_E: begin
        a_mag_r <= AW'(e_abs);
        a_neg_r <= e[W-1];
        prod_r  <= '0;
      end
      OP_LOADA_M: begin
        a_mag_r <= AW'(minor_r[MINW-1] ? $unsigned(-minor_r) : $unsigned(minor_r));
        a_neg_r <= minor_r[MINW-1];
        prod_r  <= '0;
      end
      OP_MUL: prod_r <= prod_r + (PW'(mult_w) << (cmd.limb * W));
      OP_COMMIT: begin
        a_mag_r <= prod_r[AW-1:0];
        a_neg_r <= a_neg_r ^ e[W-1];
        prod_r  <= '0;
      end
      OP_MINOR_CLR: minor_r <= '0;
      OP_MINOR_ACC: minor_r <= cmd.neg ? minor_r - MINW'(a_sv) : minor_r + MINW'(a_sv);
      OP_DET_CLR:   det_r <= '0;
      OP_DET_ACC:   det_r <= cmd.neg ? det_r - DW'(a_sv) : det_r + DW'(a_sv);
      OP_DET_FMT: begin
        detq_r <= detq_w;
        sing_r <= (det_r == '0);
      end
      OP_DIV_START: begin
        rem_r  <= num;
        dsh_r  <= den2 << (W - 1);
        quo_r  <= '0;
        qneg_r <= mv[MINW] ^ det_r[DW-1];
        ovf_r  <= ovf_w;
      end
      OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_EMIT: inv_r <= sing_r ? '0 : inv_w;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= (cmd.op == OP_EMIT);
      last_r  <= (cmd.op == OP_EMIT) && cmd.last;
    end
  end

  assign stat.singular       = sing_r;
  assign out_valid           = valid_r;
  assign out_last            = last_r;
  assign out_inverse_element = inv_r;
  assign out_determinant     = detq_r;
  assign out_singular        = sing_r;

endmodule

[hdl/matrix_inverse_4x4.sv]
// Top level of the 4x4 matrix inverse: sequencer plus datapath.
// Loading: one element per cycle, taken when start is high while busy is low; 16 transactions per matrix.
// Processing: after the 16th element the determinant is built from four minors on one
//   shared limb multiplier, then each result takes a minor and a bit-serial divide;
//   when the matrix is singular the results are emitted without either.
// Results stream out one per strobe; the receiver cannot stall. rst_n is
//   synchronous, active low, and returns the block to loading with its load count cleared.
module matrix_inverse_4x4 #(
  parameter int WORD_BITS = minv_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = minv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] in_element,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_inverse_element,
  output logic signed [WORD_BITS-1:0] out_determinant,
  output logic                        out_singular,
  output logic                        out_last
);
  import minv_pkg::*;

  dp_cmd_t  cmd;    // one datapath operation per cycle
  dp_stat_t stat;   // singular flag back to the sequencer

  // Sequencer: counts loads, then walks minors, determinant and the divider.
  minv_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Datapath: element store, exact wide arithmetic, rounding and clamping.
  minv_dp #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_element          (in_element),
    .out_valid           (out_valid),
    .out_inverse_element (out_inverse_element),
    .out_determinant     (out_determinant),
    .out_singular        (out_singular),
    .out_last            (out_last)
  );

endmodule

[hdl/minv_checker.sv]
// Port-level checks for the matrix inverse, bound to the top level.
module minv_checker #(
  parameter int WORD_BITS = minv_pkg::WORD_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input logic signed [WORD_BITS-1:0] out_inverse_element,
  input logic signed [WORD_BITS-1:0] out_determinant,
  input logic                        out_singular,
  input logic                        out_last
);

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last without strobe");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> (out_inverse_element == '0) && (out_determinant == '0))
    else $error("singular result not zero");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("loading during result stream");

  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> !busy)
    else $error("not ready after last result");

endmodule

bind matrix_inverse_4x4 minv_checker #(.WORD_BITS(WORD_BITS)) u_minv_chk (.*);
